FILE: hw/rtl/bfqd_pkg.sv
// Package with the shared types, register codes and fixed-point helpers of the drag block.
package bfqd_pkg;

  typedef logic signed [31:0] s32_t;
  typedef logic        [31:0] u32_t;

  typedef enum logic [2:0] {
    REG_LIN_COEF_X = 3'd0,
    REG_LIN_COEF_Y = 3'd1,
    REG_LIN_COEF_Z = 3'd2,
    REG_ROLL_COEF  = 3'd3,
    REG_PITCH_COEF = 3'd4,
    REG_YAW_COEF   = 3'd5
  } reg_idx_t;

  localparam u32_t LIN_COEF_X_RST = 32'd1310720;
  localparam u32_t LIN_COEF_Y_RST = 32'd2621440;
  localparam u32_t LIN_COEF_Z_RST = 32'd1966080;
  localparam u32_t ROLL_COEF_RST  = 32'd16384;
  localparam u32_t PITCH_COEF_RST = 32'd32768;
  localparam u32_t YAW_COEF_RST   = 32'd65536;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Round a product by 2^30, ties towards plus infinity (add half, then floor).
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = 65'(p) + 65'sd536870912;
    return 34'(t >>> 30);
  endfunction

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic s32_t sat32(input logic signed [63:0] v);
    if (v > S32_MAX) return 32'sh7FFFFFFF;
    if (v < S32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: hw/rtl/body_frame_quadratic_drag.sv
// Top level of the quadratic drag block with quaternion frame rotation.
//
// Usage. An input item on the in_ stream carries a body orientation quaternion
// (signed Q2.30), a world-frame vector (signed Q16.16) and a mode bit in in_tuser:
// mode 0 treats the vector as linear velocity and uses the three linear coefficients,
// mode 1 treats it as angular velocity and uses the roll, pitch and yaw coefficients.
// The block rotates the vector into the body frame, forms -C*|b|*b per axis and
// rotates that drag back into the world frame. Each item yields one result item on
// the out_ stream with the world drag, the body vector and the body drag.
// The datapath is a nine-stage pipeline: quaternion products, matrix entries,
// body products, body sums, squares, coefficient products, drag magnitude,
// world products and the output register. One item is accepted every cycle while
// out_tready is high. When the receiver stalls the whole pipeline holds, so in_tready
// falls in the same cycle; nothing is lost or repeated. Reset (rst_n low, synchronous)
// empties the pipeline and returns the six coefficients to their defaults. The cfg_
// port writes one coefficient per cycle by index and should be used while the pipeline
// is empty.
module body_frame_quadratic_drag
  import bfqd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // quat_w, quat_x, quat_y, quat_z, world_vec_x, world_vec_y, world_vec_z (lowest first)
  input  logic [223:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // drag_world_x/y/z, body_vec_x/y/z, drag_body_x/y/z (lowest first)
  output logic [287:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // Configuration registers.
  u32_t coef_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= LIN_COEF_X_RST;
      coef_r[1] <= LIN_COEF_Y_RST;
      coef_r[2] <= LIN_COEF_Z_RST;
      coef_r[3] <= ROLL_COEF_RST;
      coef_r[4] <= PITCH_COEF_RST;
      coef_r[5] <= YAW_COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LIN_COEF_X: coef_r[0] <= cfg_wdata;
        REG_LIN_COEF_Y: coef_r[1] <= cfg_wdata;
        REG_LIN_COEF_Z: coef_r[2] <= cfg_wdata;
        REG_ROLL_COEF:  coef_r[3] <= cfg_wdata;
        REG_PITCH_COEF: coef_r[4] <= cfg_wdata;
        REG_YAW_COEF:   coef_r[5] <= cfg_wdata;
        default: ; // indexes beyond the register list are ignored
      endcase
    end
  end

  // The pipeline moves as one: it advances unless the output holds an untaken item.
  logic [9:1] vld_r;
  logic       en;
  assign en        = !vld_r[9] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[8:1], in_tvalid};
    end
  end

  // Input unpacking.
  s32_t qw, qx, qy, qz;
  s32_t vin [3];
  assign qw     = in_tdata[31:0];
  assign qx     = in_tdata[63:32];
  assign qy     = in_tdata[95:64];
  assign qz     = in_tdata[127:96];
  assign vin[0] = in_tdata[159:128];
  assign vin[1] = in_tdata[191:160];
  assign vin[2] = in_tdata[223:192];

  // Stage 1: the ten quaternion products, each rounded to Q.30.
  logic signed [33:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  s32_t v1_r [3];
  logic mode1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r    <= rnd30(64'(qw) * 64'(qw));
      xx_r    <= rnd30(64'(qx) * 64'(qx));
      yy_r    <= rnd30(64'(qy) * 64'(qy));
      zz_r    <= rnd30(64'(qz) * 64'(qz));
      xy_r    <= rnd30(64'(qx) * 64'(qy));
      xz_r    <= rnd30(64'(qx) * 64'(qz));
      yz_r    <= rnd30(64'(qy) * 64'(qz));
      wx_r    <= rnd30(64'(qw) * 64'(qx));
      wy_r    <= rnd30(64'(qw) * 64'(qy));
      wz_r    <= rnd30(64'(qw) * 64'(qz));
      v1_r    <= vin;
      mode1_r <= in_tuser;
    end
  end

  // Stage 2: rotation matrix entries, saturated to Q2.30.
  logic signed [63:0] ww_e, xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
  assign ww_e = 64'(ww_r);
  assign xx_e = 64'(xx_r);
  assign yy_e = 64'(yy_r);
  assign zz_e = 64'(zz_r);
  assign xy_e = 64'(xy_r);
  assign xz_e = 64'(xz_r);
  assign yz_e = 64'(yz_r);
  assign wx_e = 64'(wx_r);
  assign wy_e = 64'(wy_r);
  assign wz_e = 64'(wz_r);

  s32_t m_nxt [3][3];
  always_comb begin
    m_nxt[0][0] = sat32(ww_e + xx_e - yy_e - zz_e);
    m_nxt[0][1] = sat32((xy_e - wz_e) <<< 1);
    m_nxt[0][2] = sat32((xz_e + wy_e) <<< 1);
    m_nxt[1][0] = sat32((xy_e + wz_e) <<< 1);
    m_nxt[1][1] = sat32(ww_e - xx_e + yy_e - zz_e);
    m_nxt[1][2] = sat32((yz_e - wx_e) <<< 1);
    m_nxt[2][0] = sat32((xz_e - wy_e) <<< 1);
    m_nxt[2][1] = sat32((yz_e + wx_e) <<< 1);
    m_nxt[2][2] = sat32(ww_e - xx_e - yy_e + zz_e);
  end

  // The matrix travels with the item until the world products are formed.
  s32_t m2_r [3][3], m3_r [3][3], m4_r [3][3], m5_r [3][3], m6_r [3][3], m7_r [3][3];
  s32_t v2_r [3];
  logic mode2_r, mode3_r, mode4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r    <= m_nxt;
      v2_r    <= v1_r;
      mode2_r <= mode1_r;
      m3_r    <= m2_r;
      m4_r    <= m3_r;
      m5_r    <= m4_r;
      m6_r    <= m5_r;
      m7_r    <= m6_r;
      mode3_r <= mode2_r;
      mode4_r <= mode3_r;
    end
  end

  // Stage 3: body products, transpose of the matrix times the vector.
  logic signed [33:0] bp_r [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          bp_r[i][j] <= rnd30(64'(m2_r[j][i]) * 64'(v2_r[j]));
        end
      end
    end
  end

  // Stage 4: body vector, summed and saturated.
  s32_t body4_r [3], body5_r [3], body6_r [3], body7_r [3], body8_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        body4_r[i] <= sat32(64'(bp_r[i][0]) + 64'(bp_r[i][1]) + 64'(bp_r[i][2]));
      end
      body5_r <= body4_r;
      body6_r <= body5_r;
      body7_r <= body6_r;
      body8_r <= body7_r;
    end
  end

  // Stage 5: squares of the body components and coefficient selection.
  logic [62:0] sq5_r [3];
  u32_t        c5_r [3];
  logic [31:0] babs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      babs[i] = body4_r[i][31] ? 32'(-body4_r[i]) : 32'(body4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= 63'(64'(babs[i]) * 64'(babs[i]));
        c5_r[i]  <= mode4_r ? coef_r[3 + i] : coef_r[i];
      end
    end
  end

  // Stage 6: coefficient times the low and high halves of the square.
  logic [63:0] lo6_r [3];
  logic [62:0] hi6_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lo6_r[i] <= 64'(c5_r[i]) * 64'(sq5_r[i][31:0]);
        hi6_r[i] <= 63'(64'(c5_r[i]) * 64'(sq5_r[i][62:32]));
      end
    end
  end

  // Stage 7: drag magnitude rounded from Q.48, signed against the body component.
  logic [63:0] hsum [3];
  logic [47:0] xrnd [3];
  logic [63:0] mag  [3];
  s32_t        dbody_nxt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hsum[i] = 64'(hi6_r[i]) + 64'(lo6_r[i][63:32]);
      xrnd[i] = 48'(lo6_r[i][31:0]) + 48'h8000_0000_0000;
      mag[i]  = (hsum[i] + 64'(xrnd[i][47:32])) >> 16;
      if (!body6_r[i][31]) begin
        dbody_nxt[i] = (mag[i] > 64'd2147483648) ? 32'sh80000000 : 32'(-mag[i]);
      end else begin
        dbody_nxt[i] = (mag[i] > 64'd2147483647) ? 32'sh7FFFFFFF : mag[i][31:0];
      end
    end
  end

  s32_t dbody7_r [3], dbody8_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      dbody7_r <= dbody_nxt;
      dbody8_r <= dbody7_r;
    end
  end

  // Stage 8: world products, matrix times body drag.
  logic signed [33:0] wp_r [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          wp_r[i][j] <= rnd30(64'(m7_r[i][j]) * 64'(dbody7_r[j]));
        end
      end
    end
  end

  // Stage 9: output register.
  s32_t dworld9_r [3], body9_r [3], dbody9_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dworld9_r[i] <= sat32(64'(wp_r[i][0]) + 64'(wp_r[i][1]) + 64'(wp_r[i][2]));
      end
      body9_r  <= body8_r;
      dbody9_r <= dbody8_r;
    end
  end

  assign out_tvalid = vld_r[9];
  assign out_tdata  = {dbody9_r[2], dbody9_r[1], dbody9_r[0],
                       body9_r[2], body9_r[1], body9_r[0],
                       dworld9_r[2], dworld9_r[1], dworld9_r[0]};

  // Checks on the pipeline control and the drag stage.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!vld_r[9] || out_tready))
    else $error("in_tready does not follow the output stage");

  a_first_stage_loads: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> vld_r[1] == $past(in_tvalid))
    else $error("first stage valid bit did not load the input");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_zero_body_no_drag: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[6] && body6_r[0] == 32'sd0) |=> dbody7_r[0] == 32'sd0)
    else $error("zero body component gave non-zero drag");

endmodule
